### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block allocator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is applied
`define FPBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FPBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fpba_pkg.sv
// ---------------------------------------------------------------------------
// Fit-policy block allocator package
// Sizes, codes and the candidate word passed along the cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CFG_BITS   = 5;
  localparam int CNT_W      = ($clog2(MAX_BLOCKS + 1) > CFG_BITS) ?
                              $clog2(MAX_BLOCKS + 1) : CFG_BITS;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [2:0] ST_ALLOCATED  = 3'd0;
  localparam logic [2:0] ST_NO_FIT     = 3'd1;
  localparam logic [2:0] ST_BAD_POLICY = 3'd2;
  localparam logic [2:0] ST_DONE       = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd4;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  typedef struct packed {
    logic  live;
    logic  found;
    idx_t  idx;
    size_t size;
  } cand_t;

endpackage

`default_nettype wire

### rtl/core/fit_policy_block_allocator_unit.sv
// ---------------------------------------------------------------------------
// Fit-policy block allocator
// Remaining-size table in a chain of cells; first, best and worst fit.
// ---------------------------------------------------------------------------
// channel   handshake                    payload
// input     start / busy                 in_operation, in_block_index,
//                                        in_size_value, in_policy
// result    out_strobe (one cycle)       out_status, out_chosen_block,
//                                        out_remaining_size
// config    cfg_valid / cfg_ready        cfg_block_count
//
// Load, read and rejected words: result strobed the next cycle.
// Allocate: the candidate word walks the cell chain one cell a cycle, from
// the inject register to the last cell; write-back comes with the strobe.
// Reset clears every block to zero and the block count to 16.
// The receiver takes every result; busy is the only input stall, and
// cfg_ready drops while busy or start is high.
// ---------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [3:0]  in_block_index,
  input  wire logic [15:0] in_size_value,
  input  wire logic [1:0]  in_policy,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [3:0]       out_chosen_block,
  output logic [15:0]      out_remaining_size,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_block_count
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                        state_r;
  logic                          inj_r;
  logic [fpba_pkg::CFG_BITS-1:0] count_r;
  fpba_pkg::size_t               req_r;
  logic [1:0]                    policy_r;
  logic                          strobe_r;
  logic [2:0]                    status_r;
  logic [3:0]                    chosen_r;
  logic [15:0]                   remain_r;

  fpba_pkg::cand_t               cands [fpba_pkg::MAX_BLOCKS];
  fpba_pkg::size_t               sizes [fpba_pkg::MAX_BLOCKS];
  logic [fpba_pkg::MAX_BLOCKS-1:0] wr_en;
  fpba_pkg::cand_t               inject;
  fpba_pkg::cand_t               chain_end;
  fpba_pkg::size_t               wr_data;
  fpba_pkg::size_t               new_size;
  fpba_pkg::size_t               in_size;
  fpba_pkg::size_t               rd_size;
  logic [fpba_pkg::CNT_W-1:0]    count_ext;
  logic [fpba_pkg::CNT_W-1:0]    in_use;
  logic [fpba_pkg::CNT_W-1:0]    idx_ext;
  fpba_pkg::idx_t                addr;
  logic                          idx_ok;
  logic                          accept;
  logic                          done;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;

  always_comb begin
    count_ext = fpba_pkg::CNT_W'(count_r);
    in_use    = (count_ext > fpba_pkg::CNT_W'(fpba_pkg::MAX_BLOCKS)) ?
                fpba_pkg::CNT_W'(fpba_pkg::MAX_BLOCKS) : count_ext;
    idx_ext   = fpba_pkg::CNT_W'(in_block_index);
    idx_ok    = idx_ext < in_use;
    addr      = idx_ext[fpba_pkg::IDX_BITS-1:0];
    rd_size   = sizes[addr];
    in_size   = fpba_pkg::SIZE_BITS'(in_size_value);

    inject       = '0;
    inject.live  = inj_r;
    chain_end    = cands[fpba_pkg::MAX_BLOCKS-1];
    done         = (state_r == S_SCAN) && chain_end.live;
    new_size     = chain_end.size - req_r;
    wr_data      = (state_r == S_SCAN) ? new_size : in_size;
  end

  for (genvar g = 0; g < fpba_pkg::MAX_BLOCKS; g++) begin : g_cell
    fpba_pkg::cand_t cin;

    assign wr_en[g] = (accept && (in_operation == fpba_pkg::OP_LOAD) && idx_ok &&
                       (addr == fpba_pkg::IDX_BITS'(g))) ||
                      (done && chain_end.found &&
                       (chain_end.idx == fpba_pkg::IDX_BITS'(g)));

    if (g == 0) begin : g_head
      assign cin = inject;
    end else begin : g_link
      assign cin = cands[g-1];
    end

    fpba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (fpba_pkg::IDX_BITS'(g)),
      .active   (fpba_pkg::CNT_W'(g) < in_use),
      .req_size (req_r),
      .policy   (policy_r),
      .cand_in  (cin),
      .cand_out (cands[g]),
      .wr_en    (wr_en[g]),
      .wr_data  (wr_data),
      .size_out (sizes[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      inj_r    <= 1'b0;
      strobe_r <= 1'b0;
      count_r  <= fpba_pkg::CFG_RESET;
    end else begin
      strobe_r <= 1'b0;
      inj_r    <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_block_count;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r    <= in_size;
            policy_r <= in_policy;
            if ((in_operation == fpba_pkg::OP_LOAD) ||
                (in_operation == fpba_pkg::OP_READ)) begin
              strobe_r <= 1'b1;
              chosen_r <= in_block_index;
              if (!idx_ok) begin
                status_r <= fpba_pkg::ST_BAD_INDEX;
                remain_r <= '0;
              end else begin
                status_r <= fpba_pkg::ST_DONE;
                remain_r <= (in_operation == fpba_pkg::OP_LOAD) ?
                            16'(in_size) : 16'(rd_size);
              end
            end else if ((in_operation == fpba_pkg::OP_ALLOC) &&
                         ((in_policy == fpba_pkg::POL_FIRST) ||
                          (in_policy == fpba_pkg::POL_BEST) ||
                          (in_policy == fpba_pkg::POL_WORST))) begin
              state_r <= S_SCAN;
              inj_r   <= 1'b1;
            end else begin
              strobe_r <= 1'b1;
              status_r <= fpba_pkg::ST_BAD_POLICY;
              chosen_r <= '0;
              remain_r <= '0;
            end
          end
        end
        S_SCAN: begin
          if (done) begin
            state_r  <= S_IDLE;
            strobe_r <= 1'b1;
            if (chain_end.found) begin
              status_r <= fpba_pkg::ST_ALLOCATED;
              chosen_r <= 4'(chain_end.idx);
              remain_r <= 16'(new_size);
            end else begin
              status_r <= fpba_pkg::ST_NO_FIT;
              chosen_r <= '0;
              remain_r <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_chosen_block   = chosen_r;
  assign out_remaining_size = remain_r;

endmodule

`default_nettype wire

### rtl/core/fpba_cell.sv
// ---------------------------------------------------------------------------
// Allocator cell
// Holds one block's remaining size and refines the passing candidate word.
// ---------------------------------------------------------------------------
`default_nettype none

module fpba_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire fpba_pkg::idx_t  cell_idx,
  input  wire logic           active,
  input  wire fpba_pkg::size_t req_size,
  input  wire logic [1:0]     policy,
  input  wire fpba_pkg::cand_t cand_in,
  output fpba_pkg::cand_t     cand_out,
  input  wire logic           wr_en,
  input  wire fpba_pkg::size_t wr_data,
  output fpba_pkg::size_t     size_out
);

  fpba_pkg::size_t size_r;
  fpba_pkg::cand_t cand_r;
  fpba_pkg::cand_t cand_nxt;
  logic            fits;
  logic            take;

  always_comb begin
    fits = active && (size_r >= req_size);
    take = fits && (!cand_in.found ||
                    ((policy == fpba_pkg::POL_BEST)  && (size_r < cand_in.size)) ||
                    ((policy == fpba_pkg::POL_WORST) && (size_r > cand_in.size)));
    cand_nxt = cand_in;
    if (cand_in.live && take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.idx   = cell_idx;
      cand_nxt.size  = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
      if (wr_en) begin
        size_r <= wr_data;
      end
    end
  end

  assign cand_out = cand_r;
  assign size_out = size_r;

endmodule

`default_nettype wire

### rtl/core/fpba_checker.sv
// ---------------------------------------------------------------------------
// Allocator port checker
// Timing and result properties seen on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fpba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_operation,
  input wire logic [1:0]  in_policy,
  input wire logic        out_strobe,
  input wire logic [2:0]  out_status,
  input wire logic [3:0]  out_chosen_block,
  input wire logic [15:0] out_remaining_size
);

  `FPBA_ASSERT(a_quick_word, clk, rst_n, (start && !busy && (in_operation != fpba_pkg::OP_ALLOC)) |=> (out_strobe && !busy), "load, read or bad word must answer next cycle")
  `FPBA_ASSERT(a_alloc_busy, clk, rst_n, (start && !busy && (in_operation == fpba_pkg::OP_ALLOC) && (in_policy != 2'd3)) |=> (busy && !out_strobe), "allocate must hold busy")
  `FPBA_ASSERT(a_end_strobe, clk, rst_n, $fell(busy) |-> out_strobe, "allocate end without result")
  `FPBA_ASSERT(a_reject_zero, clk, rst_n, (out_strobe && ((out_status == fpba_pkg::ST_BAD_POLICY) || (out_status == fpba_pkg::ST_NO_FIT))) |-> ((out_chosen_block == 4'd0) && (out_remaining_size == 16'd0)), "rejected word must report zeros")
  `FPBA_ASSERT_ALWAYS(a_status_range, clk, out_strobe |-> (out_status <= fpba_pkg::ST_BAD_INDEX), "status code out of range")

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (.*);

`default_nettype wire
